// File: src/pcm_pkg.sv
// Package for the pointwise convolution MAC: field widths, stream layout,
// command codes and the command record passed from front to back.
// No dependencies.
`default_nettype none

package pcm_pkg;

	// Field widths of the stream items
	localparam int IDX_BITS     = 5;
	localparam int FUNC_BITS    = 2;
	localparam int WEIGHT_BITS  = 11;
	localparam int FEATURE_BITS = 16;
	localparam int SUM_BITS     = 32;
	localparam int PROD_BITS    = WEIGHT_BITS + FEATURE_BITS;

	// Input tdata layout, lowest field first
	localparam int OFS_OUT_IDX  = 0;
	localparam int OFS_IN_IDX   = OFS_OUT_IDX + IDX_BITS;
	localparam int OFS_WEIGHT   = OFS_IN_IDX + IDX_BITS;
	localparam int OFS_FEATURE  = OFS_WEIGHT + WEIGHT_BITS;
	localparam int OFS_START    = OFS_FEATURE + FEATURE_BITS;
	localparam int S_TDATA_BITS = 72;

	// Output tdata layout
	localparam int M_TDATA_BITS = 40;
	localparam int M_PAD_BITS   = M_TDATA_BITS - IDX_BITS - SUM_BITS;

	// Function codes carried in s_tuser, also used as command codes
	localparam logic [FUNC_BITS-1:0] OP_WEIGHT  = 2'd0;
	localparam logic [FUNC_BITS-1:0] OP_PRELOAD = 2'd1;
	localparam logic [FUNC_BITS-1:0] OP_FEATURE = 2'd2;

	// One classified command waiting for the back end
	typedef struct packed {
		logic [FUNC_BITS-1:0] op;
		logic [IDX_BITS-1:0]  out_index;
		logic [IDX_BITS-1:0]  in_index;
		logic [SUM_BITS-1:0]  data;
		logic                 add_en;
		logic                 done;
	} cmd_t;

endpackage

`default_nettype wire

// File: src/pcm_front.sv
// Front end of the pointwise convolution MAC: accepts stream transactions,
// drops items that do nothing, and queues commands for the back end.
// Depends on pcm_pkg.
`default_nettype none

module pcm_front #(
	parameter int IN_CHANNELS  = 32,
	parameter int OUT_CHANNELS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [pcm_pkg::S_TDATA_BITS-1:0] s_tdata,
	input  wire logic [pcm_pkg::FUNC_BITS-1:0]    s_tuser,
	input  wire logic                             s_tlast,
	output logic                                  cmd_valid,
	input  wire logic                             cmd_ready,
	output pcm_pkg::cmd_t                         cmd
);
	import pcm_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [IDX_BITS-1:0]     out_idx;
	logic [IDX_BITS-1:0]     in_idx;
	logic                    out_ok;
	logic                    in_ok;
	logic                    keep;
	logic                    push;
	logic                    pop;
	cmd_t                    new_cmd;
	cmd_t                    queue_q [DEPTH];
	logic [PW-1:0]           wptr_q;
	logic [PW-1:0]           rptr_q;
	logic [PW:0]             count_q;

	assign out_idx = s_tdata[OFS_OUT_IDX +: IDX_BITS];
	assign in_idx  = s_tdata[OFS_IN_IDX +: IDX_BITS];
	assign out_ok  = ({1'b0, out_idx} < (IDX_BITS+1)'(OUT_CHANNELS));
	assign in_ok   = ({1'b0, in_idx} < (IDX_BITS+1)'(IN_CHANNELS));

	// Classify the item and build its command
	always_comb begin
		new_cmd           = '0;
		new_cmd.op        = s_tuser;
		new_cmd.out_index = out_idx;
		new_cmd.in_index  = in_idx;
		keep              = 1'b0;
		case (s_tuser)
			OP_WEIGHT: begin
				new_cmd.data = {{(SUM_BITS-WEIGHT_BITS){1'b0}},
					s_tdata[OFS_WEIGHT +: WEIGHT_BITS]};
				keep = out_ok && in_ok;
			end
			OP_PRELOAD: begin
				new_cmd.data = s_tdata[OFS_START +: SUM_BITS];
				keep = out_ok;
			end
			OP_FEATURE: begin
				new_cmd.data = {{(SUM_BITS-FEATURE_BITS){1'b0}},
					s_tdata[OFS_FEATURE +: FEATURE_BITS]};
				new_cmd.add_en = in_ok;
				new_cmd.done   = s_tlast;
				keep = in_ok || s_tlast;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready  = (count_q != (PW+1)'(DEPTH));
	assign push      = s_tvalid && s_tready && keep;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rptr_q];

	// Store queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= new_cmd;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/pcm_back.sv
// Back end of the pointwise convolution MAC: per-lane weight memories,
// one multiplier per output channel, partial sums and result emission.
// Depends on pcm_pkg.
`default_nettype none

module pcm_back #(
	parameter int IN_CHANNELS  = 32,
	parameter int OUT_CHANNELS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_valid,
	output logic                                  cmd_ready,
	input  wire pcm_pkg::cmd_t                    cmd,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [pcm_pkg::M_TDATA_BITS-1:0]      m_tdata,
	output logic                                  m_tlast
);
	import pcm_pkg::*;

	localparam int IN_AW  = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
	localparam int OUT_CW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                     state_q;
	logic [IN_AW-1:0]               mem_addr;
	logic                           take;
	logic                           emit_step;
	logic                           emit_last;
	logic [WEIGHT_BITS-1:0]         rdata_q [OUT_CHANNELS];
	logic signed [PROD_BITS-1:0]    prod_q [OUT_CHANNELS];
	logic [SUM_BITS-1:0]            sums_q [OUT_CHANNELS];
	logic signed [FEATURE_BITS-1:0] feat_q;
	logic                           add_q;
	logic                           done_q;
	logic [OUT_CW-1:0]              ch_q;
	logic                           out_valid_q;
	logic                           out_last_q;
	logic [IDX_BITS-1:0]            out_ch_q;
	logic [SUM_BITS-1:0]            out_sum_q;

	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign mem_addr  = cmd.in_index[IN_AW-1:0];
	assign emit_step = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign emit_last = (ch_q == OUT_CW'(OUT_CHANNELS - 1));

	// One weight memory and one multiplier per output channel
	for (genvar k = 0; k < OUT_CHANNELS; k++) begin : g_lane
		logic [WEIGHT_BITS-1:0] mem [IN_CHANNELS];
		logic                   we;

		assign we = take && (cmd.op == OP_WEIGHT) && (cmd.out_index == IDX_BITS'(k));

		// Write weight, read the row addressed by the head command
		always_ff @(posedge clk) begin
			if (we) begin
				mem[mem_addr] <= cmd.data[WEIGHT_BITS-1:0];
			end
			rdata_q[k] <= mem[mem_addr];
		end

		// Multiply weight by feature
		always_ff @(posedge clk) begin
			if (state_q == ST_MUL) begin
				prod_q[k] <= PROD_BITS'($signed(rdata_q[k])) * PROD_BITS'(feat_q);
			end
		end
	end

	// Latch feature operands
	always_ff @(posedge clk) begin
		if (take && (cmd.op == OP_FEATURE)) begin
			feat_q <= cmd.data[FEATURE_BITS-1:0];
			add_q  <= cmd.add_en;
			done_q <= cmd.done;
		end
	end

	// Preload, accumulate and clear partial sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < OUT_CHANNELS; k++) begin
				sums_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < OUT_CHANNELS; k++) begin
				if (take && (cmd.op == OP_PRELOAD) && (cmd.out_index == IDX_BITS'(k))) begin
					sums_q[k] <= cmd.data;
				end else if ((state_q == ST_ACC) && add_q) begin
					sums_q[k] <= sums_q[k] + {{(SUM_BITS-PROD_BITS){prod_q[k][PROD_BITS-1]}},
						prod_q[k]};
				end else if (emit_step && (ch_q == OUT_CW'(k))) begin
					sums_q[k] <= '0;
				end
			end
		end
	end

	// Sequence commands and walk the channels at pixel end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && (cmd.op == OP_FEATURE)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					ch_q    <= '0;
					state_q <= done_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_step) begin
						ch_q <= ch_q + 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold a result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_ch_q   <= IDX_BITS'(ch_q);
			out_sum_q  <= sums_q[ch_q];
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{M_PAD_BITS{1'b0}}, out_sum_q, out_ch_q};

endmodule

`default_nettype wire

// File: src/pointwise_conv_mac.sv
// A weight load or preload passes the command queue and takes effect when the
// back end accepts it; a feature item passes the queue, then read, multiply and add.
// Throughput: one weight load or preload per cycle while the back end is idle; a
// feature item holds the back end for the shared read/multiply/accumulate sequence,
// and a pixel end adds emission, one channel sum per cycle while m_tready is high.
// Reset (arst_n low) empties the queue and output register and zeroes all sums.
// Top level of the pointwise convolution MAC: front end, command queue, back end.
// Depends on pcm_pkg, pcm_front and pcm_back.
`default_nettype none

module pointwise_conv_mac #(
	parameter int IN_CHANNELS  = 32,
	parameter int OUT_CHANNELS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// out_index[4:0], in_index[9:5], weight_value[20:10], feature_value[36:21],
	// start_sum[68:37], zero pad[71:69]
	input  wire logic [pcm_pkg::S_TDATA_BITS-1:0] s_tdata,
	// func[1:0]
	input  wire logic [pcm_pkg::FUNC_BITS-1:0]    s_tuser,
	// pixel_done
	input  wire logic                             s_tlast,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// result_channel[4:0], channel_sum[36:5], zero pad[39:37]
	output logic [pcm_pkg::M_TDATA_BITS-1:0]      m_tdata,
	// last_channel
	output logic                                  m_tlast
);
	import pcm_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	pcm_front #(
		.IN_CHANNELS (IN_CHANNELS),
		.OUT_CHANNELS(OUT_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	pcm_back #(
		.IN_CHANNELS (IN_CHANNELS),
		.OUT_CHANNELS(OUT_CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// File: src/pcm_checker.sv
// Port-level checks on the result stream of the pointwise convolution MAC,
// bound to the top level. Depends on pcm_pkg and pointwise_conv_mac.
`default_nettype none

module pcm_checker #(
	parameter int OUT_CHANNELS = 32
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [pcm_pkg::M_TDATA_BITS-1:0] m_tdata,
	input wire logic                             m_tlast
);
	import pcm_pkg::*;

	// A stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// The marked result is the top channel
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[IDX_BITS-1:0] == IDX_BITS'(OUT_CHANNELS - 1))
		else $error("last flag on wrong channel");

	// Channels advance by one within a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !m_tvalid ||
			(m_tdata[IDX_BITS-1:0] == IDX_BITS'($past(m_tdata[IDX_BITS-1:0]) + 1'b1)))
		else $error("channel order broken");

	// Pad bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_BITS-1 -: M_PAD_BITS] == '0)
		else $error("pad bits set");

endmodule

bind pointwise_conv_mac pcm_checker #(.OUT_CHANNELS(OUT_CHANNELS)) u_pcm_checker (.*);

`default_nettype wire
